@@ hdl/wpm_pkg.sv @@
`timescale 1ns / 1ps

package wpm_pkg;

  // Pattern geometry
  localparam int PATTERN_MAX = 32;
  localparam int POS_W       = PATTERN_MAX + 1;
  localparam int PAT_BYTES   = 32;
  localparam int PAT_USE     = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam int LEN_W       = 6;
  localparam int CFG_W       = 64;
  localparam int IDX_W       = 3;

  // Wildcard characters
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Configuration register map
  typedef enum logic [IDX_W-1:0] {
    REG_BYTES_A = 3'd0,
    REG_BYTES_B = 3'd1,
    REG_BYTES_C = 3'd2,
    REG_BYTES_D = 3'd3,
    REG_LENGTH  = 3'd4
  } reg_idx_t;

  typedef logic [POS_W-1:0] pos_vec_t;

  // Decoded pattern, one bit per position
  typedef struct packed {
    pos_vec_t                   keep;   // position <= length
    pos_vec_t                   used;   // position < length
    pos_vec_t                   skip;   // '*' or '?' in use
    pos_vec_t                   star;   // '*' in use
    pos_vec_t                   wild;   // '?' or '.' in use
    logic [PAT_BYTES-1:0][7:0]  bytes;
    logic [LEN_W-1:0]           len;    // saturated length
  } pattern_t;

  // Hand-off from the step stage to the verdict stage
  typedef struct packed {
    logic     valid;
    pos_vec_t vec;
  } pend_t;

  localparam pos_vec_t START_SET = pos_vec_t'(1);

  // Drop positions past the length, then follow runs of '*' and '?'.
  // Adding the skip mask to the active skip bits carries through each run
  // and lands one past its end, which marks every reachable position.
  function automatic pos_vec_t close_set(pos_vec_t act, pos_vec_t keep, pos_vec_t skip);
    pos_vec_t a;
    pos_vec_t t;
    a = act & keep;
    t = ((a & skip) + skip) ^ skip;
    return a | t;
  endfunction

endpackage

@@ hdl/wpm_cfg.sv @@
`timescale 1ns / 1ps

module wpm_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [wpm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [wpm_pkg::CFG_W-1:0]   cfg_data,
  output wpm_pkg::pattern_t           pat
);

  logic [wpm_pkg::CFG_W-1:0] bytes_a;
  logic [wpm_pkg::CFG_W-1:0] bytes_b;
  logic [wpm_pkg::CFG_W-1:0] bytes_c;
  logic [wpm_pkg::CFG_W-1:0] bytes_d;
  logic [wpm_pkg::LEN_W-1:0] len_reg;
  logic [wpm_pkg::LEN_W-1:0] len_sat;

  // Store a written word; unknown indexes drop it
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_a <= '0;
      bytes_b <= '0;
      bytes_c <= '0;
      bytes_d <= '0;
      len_reg <= '0;
    end else if (cfg_valid) begin
      unique case (wpm_pkg::reg_idx_t'(cfg_index))
        wpm_pkg::REG_BYTES_A: bytes_a <= cfg_data;
        wpm_pkg::REG_BYTES_B: bytes_b <= cfg_data;
        wpm_pkg::REG_BYTES_C: bytes_c <= cfg_data;
        wpm_pkg::REG_BYTES_D: bytes_d <= cfg_data;
        wpm_pkg::REG_LENGTH:  len_reg <= cfg_data[wpm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the length to the usable pattern size
  assign len_sat = (len_reg > wpm_pkg::LEN_W'(wpm_pkg::PAT_USE))
                   ? wpm_pkg::LEN_W'(wpm_pkg::PAT_USE) : len_reg;

  // Decode per-position masks
  always_comb begin
    pat       = '0;
    pat.len   = len_sat;
    pat.bytes = {bytes_d, bytes_c, bytes_b, bytes_a};
    for (int p = 0; p < wpm_pkg::POS_W; p++) begin
      pat.keep[p] = (p <= int'(len_sat));
    end
    for (int p = 0; p < wpm_pkg::PAT_USE; p++) begin
      pat.used[p] = (p < int'(len_sat));
      pat.star[p] = pat.used[p] && (pat.bytes[p] == wpm_pkg::CH_STAR);
      pat.skip[p] = pat.used[p] && ((pat.bytes[p] == wpm_pkg::CH_STAR) ||
                                    (pat.bytes[p] == wpm_pkg::CH_QMARK));
      pat.wild[p] = pat.used[p] && ((pat.bytes[p] == wpm_pkg::CH_QMARK) ||
                                    (pat.bytes[p] == wpm_pkg::CH_DOT));
    end
  end

endmodule

@@ hdl/wpm_core.sv @@
`timescale 1ns / 1ps

module wpm_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [7:0]        text_byte,
  input  logic              byte_present,
  input  logic              end_of_text,
  input  wpm_pkg::pattern_t pat,
  input  logic              pend_take,
  output wpm_pkg::pend_t    pend
);

  wpm_pkg::pos_vec_t active;
  wpm_pkg::pos_vec_t closed;
  wpm_pkg::pos_vec_t lit_eq;
  wpm_pkg::pos_vec_t move;
  wpm_pkg::pos_vec_t stepped;
  wpm_pkg::pos_vec_t final_set;
  logic              accept;

  // Hold input while a verdict waits and the output cannot take it
  assign item_stall = pend.valid && !pend_take;
  assign accept     = item_valid && !item_stall;

  // Literal compare against the text byte
  always_comb begin
    lit_eq = '0;
    for (int p = 0; p < wpm_pkg::PAT_USE; p++) begin
      lit_eq[p] = pat.used[p] && (pat.bytes[p] == text_byte);
    end
  end

  // Close, then advance every active position by one text byte
  assign closed    = wpm_pkg::close_set(active, pat.keep, pat.skip);
  assign move      = pat.wild | lit_eq;
  assign stepped   = (closed & pat.star) | ((closed & move) << 1);
  assign final_set = byte_present ? stepped : active;

  // Advance the active set; restart after an end word
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= wpm_pkg::START_SET;
    end else if (accept) begin
      active <= end_of_text ? wpm_pkg::START_SET : final_set;
    end
  end

  // Hand the closing set to the verdict stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid <= 1'b0;
    end else if (accept && end_of_text) begin
      pend.valid <= 1'b1;
      pend.vec   <= final_set;
    end else if (pend_take) begin
      pend.valid <= 1'b0;
    end
  end

endmodule

@@ hdl/wpm_verdict.sv @@
`timescale 1ns / 1ps

module wpm_verdict (
  input  logic              clk,
  input  logic              rst,
  input  wpm_pkg::pend_t    pend,
  input  wpm_pkg::pattern_t pat,
  output logic              pend_take,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              text_matches
);

  wpm_pkg::pos_vec_t closed;

  // Output register is free when empty or being drained
  assign pend_take = !result_valid || !result_stall;

  // Follow trailing skips, then look at the final position
  assign closed = wpm_pkg::close_set(pend.vec, pat.keep, pat.skip);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pend_take) begin
      result_valid <= pend.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_take && pend.valid) begin
      text_matches <= closed[pat.len];
    end
  end

endmodule

@@ hdl/wildcard_pattern_matcher_unit.sv @@
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// item      item_valid / item_stall  text_byte, byte_present, end_of_text
// result    result_valid / result_stall  text_matches
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item per cycle is taken while item_stall is low; the active-position set
// is updated in the same cycle by one 33-bit carry chain that follows '*' and
// '?' runs. A verdict passes through the closing-set register and then the
// result register after its end word.
// Synchronous reset clears the pattern and restarts at position 0.
// A stalled result blocks new items only once the closing-set register is full.

module wildcard_pattern_matcher_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [7:0]                  text_byte,
  input  logic                        byte_present,
  input  logic                        end_of_text,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        text_matches,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wpm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [wpm_pkg::CFG_W-1:0]   cfg_data
);

  wpm_pkg::pattern_t pat;
  wpm_pkg::pend_t    pend;
  logic              pend_take;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  wpm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat       (pat)
  );

  wpm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .text_byte    (text_byte),
    .byte_present (byte_present),
    .end_of_text  (end_of_text),
    .pat          (pat),
    .pend_take    (pend_take),
    .pend         (pend)
  );

  wpm_verdict u_verdict (
    .clk          (clk),
    .rst          (rst),
    .pend         (pend),
    .pat          (pat),
    .pend_take    (pend_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .text_matches (text_matches)
  );

endmodule

@@ tb/wildcard_pattern_matcher_unit_tb.sv @@
`timescale 1ns / 1ps

module wildcard_pattern_matcher_unit_tb;

  localparam int RANDOM_WORDS = 340;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 150;
  localparam int REG_IDX_LAST = (1 << wpm_pkg::IDX_W) - 1;
  localparam int MAX_REPORTS  = 10;
  localparam bit [7:0] LETTER_A = "a";

  logic                      clk;
  logic                      rst;
  logic                      item_valid;
  logic                      item_stall;
  logic [7:0]                text_byte;
  logic                      byte_present;
  logic                      end_of_text;
  logic                      result_valid;
  logic                      result_stall;
  logic                      text_matches;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [wpm_pkg::IDX_W-1:0] cfg_index;
  logic [wpm_pkg::CFG_W-1:0] cfg_data;

  // Shadow of the matcher: pattern registers and active positions
  bit [63:0]               pattern_word [4];
  bit [wpm_pkg::LEN_W-1:0] pattern_len_reg;
  bit [wpm_pkg::POS_W-1:0] live_positions;
  bit                      verdicts_due [$];

  // Stimulus state
  bit [7:0] pat_draft [wpm_pkg::PAT_BYTES];
  int       pat_len_draft;
  bit [7:0] text_q [$];
  bit       steady;
  int       words_sent;
  int       hold_left;
  int       stall_left;
  int       mismatches;
  int       cycle_count;
  bit       expected_match;

  wildcard_pattern_matcher_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .text_byte    (text_byte),
    .byte_present (byte_present),
    .end_of_text  (end_of_text),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .text_matches (text_matches),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Matcher shadow
  // ---------------------------------------------------------------------------

  function automatic bit [7:0] pattern_char(int k);
    if (k >= wpm_pkg::PAT_BYTES) return 8'h00;
    return pattern_word[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic int effective_length();
    int n;
    n = int'(pattern_len_reg);
    if (n > wpm_pkg::PAT_BYTES) n = wpm_pkg::PAT_BYTES;
    if (n > wpm_pkg::PATTERN_MAX) n = wpm_pkg::PATTERN_MAX;
    return n;
  endfunction

  // Drop positions past the length, then walk forward through '*' and '?'
  function automatic void follow_skips(int n);
    bit [7:0] c;
    for (int p = n + 1; p <= wpm_pkg::PATTERN_MAX; p++) live_positions[p] = 1'b0;
    for (int p = 0; p < n; p++) begin
      c = pattern_char(p);
      if (live_positions[p] && (c == wpm_pkg::CH_STAR || c == wpm_pkg::CH_QMARK))
        live_positions[p + 1] = 1'b1;
    end
  endfunction

  // Consume one word; an end word queues the verdict and restarts at position 0
  function automatic void advance_matcher(bit [7:0] b, bit present, bit eot);
    int                      n;
    bit [wpm_pkg::POS_W-1:0] next_set;
    bit [7:0]                c;
    n = effective_length();
    if (present) begin
      follow_skips(n);
      next_set = '0;
      for (int p = 0; p < n; p++) begin
        if (live_positions[p]) begin
          c = pattern_char(p);
          if (c == wpm_pkg::CH_STAR) next_set[p] = 1'b1;
          else if (c == wpm_pkg::CH_QMARK || c == wpm_pkg::CH_DOT || c == b)
            next_set[p + 1] = 1'b1;
        end
      end
      live_positions = next_set;
    end
    if (eot) begin
      follow_skips(n);
      verdicts_due.push_back(live_positions[n]);
      live_positions = wpm_pkg::START_SET;
    end
  endfunction

  function automatic void apply_register(logic [wpm_pkg::IDX_W-1:0] idx,
                                         logic [wpm_pkg::CFG_W-1:0] data);
    case (idx)
      wpm_pkg::REG_BYTES_A: pattern_word[0] = data;
      wpm_pkg::REG_BYTES_B: pattern_word[1] = data;
      wpm_pkg::REG_BYTES_C: pattern_word[2] = data;
      wpm_pkg::REG_BYTES_D: pattern_word[3] = data;
      wpm_pkg::REG_LENGTH:  pattern_len_reg = data[wpm_pkg::LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [7:0] random_pattern_char();
    if ($urandom_range(0, 99) >= 85) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: return wpm_pkg::CH_STAR;
      1: return wpm_pkg::CH_QMARK;
      2: return wpm_pkg::CH_DOT;
      default: return 8'(LETTER_A + $urandom_range(0, 2));
    endcase
  endfunction

  function automatic bit [7:0] random_text_char();
    if ($urandom_range(0, 99) >= 85) return 8'($urandom_range(0, 255));
    return 8'(LETTER_A + $urandom_range(0, 2));
  endfunction

  // Build a text that the drafted pattern accepts
  function automatic void derive_text();
    int n;
    bit [7:0] c;
    n = (pat_len_draft > wpm_pkg::PAT_BYTES) ? wpm_pkg::PAT_BYTES : pat_len_draft;
    text_q.delete();
    for (int p = 0; p < n; p++) begin
      c = pat_draft[p];
      if (c == wpm_pkg::CH_STAR) begin
        repeat ($urandom_range(0, 3)) text_q.push_back(random_text_char());
      end else if (c == wpm_pkg::CH_QMARK) begin
        if ($urandom_range(0, 1)) text_q.push_back(random_text_char());
      end else if (c == wpm_pkg::CH_DOT) begin
        text_q.push_back(random_text_char());
      end else begin
        text_q.push_back(c);
      end
    end
  endfunction

  // Replace, drop or insert one byte
  function automatic void mutate_text();
    int idx;
    idx = (text_q.size() == 0) ? 0 : $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 2))
      0: if (text_q.size() != 0) text_q[idx] = random_text_char();
      1: if (text_q.size() != 0) text_q.delete(idx);
      default: text_q.insert(idx, random_text_char());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one word after an optional gap, hold it until taken
  task automatic send_word(bit [7:0] b, bit present, bit eot);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid   <= 1'b1;
    text_byte    <= b;
    byte_present <= present;
    end_of_text  <= eot;
    do @(posedge clk); while (item_stall);
    advance_matcher(b, present, eot);
    if (present || eot) words_sent++;
  endtask

  // Send text_q; close it with the last byte or with a bare end word
  task automatic send_text(bit bare, bit idle_mix);
    int last;
    last = text_q.size() - 1;
    for (int i = 0; i <= last; i++) begin
      if (idle_mix && $urandom_range(0, 9) == 0)
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_word(text_q[i], 1'b1, (i == last) && !bare);
    end
    if (bare || last < 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_string(string s, bit bare);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text(bare, 1'b0);
  endtask

  // Stop offering, wait for every verdict, then let the pipeline empty
  task automatic wait_drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [wpm_pkg::IDX_W-1:0] idx, logic [wpm_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pack pat_draft into the four byte registers, then write the length
  task automatic write_pattern(bit [63:0] len_data);
    bit [63:0] w;
    wait_drain();
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 8; k++) w[k * 8 +: 8] = pat_draft[i * 8 + k];
      cfg_write(wpm_pkg::IDX_W'(wpm_pkg::REG_BYTES_A + i), w);
    end
    cfg_write(wpm_pkg::REG_LENGTH, len_data);
  endtask

  task automatic load_text_pattern(string s);
    for (int k = 0; k < wpm_pkg::PAT_BYTES; k++) pat_draft[k] = (k < s.len()) ? s[k] : 8'h00;
    pat_len_draft = s.len();
    write_pattern(64'(s.len()));
  endtask

  // Mostly short patterns, some full, a few past the saturation point
  task automatic draw_pattern();
    int        r;
    bit [63:0] len_data;
    for (int k = 0; k < wpm_pkg::PAT_BYTES; k++) pat_draft[k] = random_pattern_char();
    r = $urandom_range(0, 99);
    if (r < 70) pat_len_draft = $urandom_range(0, 8);
    else if (r < 90) pat_len_draft = $urandom_range(9, 32);
    else pat_len_draft = $urandom_range(33, 63);
    len_data = 64'(pat_len_draft);
    if ($urandom_range(0, 3) == 0) len_data = ({$urandom, $urandom} & ~64'h3F) | len_data;
    write_pattern(len_data);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset pattern is empty: only the empty text matches; idle word is a no-op
  task automatic test_empty_pattern();
    send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    send_word(LETTER_A, 1'b1, 1'b1);
  endtask

  // Star runs, optional byte absent, dot needing a byte
  task automatic test_wildcards();
    load_text_pattern("a*b?c.");
    send_string("axxbcd", 1'b0);
    send_string("abcz", 1'b0);
    send_string("abc", 1'b1);
  endtask

  task automatic test_extreme_bytes();
    for (int k = 0; k < wpm_pkg::PAT_BYTES; k++) pat_draft[k] = 8'h00;
    pat_draft[1] = 8'hFF;
    pat_len_draft = 2;
    write_pattern(64'd2);
    text_q = '{8'h00, 8'hFF};
    send_text(1'b0, 1'b0);
  endtask

  // Length 63 saturates to the full pattern of optional bytes
  task automatic test_long_length();
    for (int k = 0; k < wpm_pkg::PAT_BYTES; k++) pat_draft[k] = wpm_pkg::CH_QMARK;
    pat_len_draft = 63;
    write_pattern(64'd63);
    send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Writes past the register map must not disturb the pattern
  task automatic test_unknown_index();
    wait_drain();
    for (int i = wpm_pkg::REG_LENGTH + 1; i <= REG_IDX_LAST; i++)
      cfg_write(wpm_pkg::IDX_W'(i), '1);
    send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Keep the active set across a pattern change in the middle of a text
  task automatic test_midtext_reconfig();
    load_text_pattern("ab");
    send_word(LETTER_A, 1'b1, 1'b0);
    load_text_pattern("a*");
    send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Hold the result side while end words keep coming, then drain fully
  task automatic test_backpressure();
    draw_pattern();
    hold_left = LONG_HOLD;
    steady = 1'b1;
    repeat (30) send_word(random_text_char(), 1'($urandom_range(0, 1)), 1'b1);
    steady = 1'b0;
    wait_drain();
  endtask

  task automatic test_random_texts();
    int phase;
    int pick;
    phase = 0;
    while (words_sent < RANDOM_WORDS) begin
      steady = (phase % 4 == 3);
      draw_pattern();
      repeat ($urandom_range(6, 12)) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          derive_text();
          if (pick >= 50) mutate_text();
        end else begin
          text_q.delete();
          repeat ($urandom_range(0, 8)) text_q.push_back(random_text_char());
        end
        send_text($urandom_range(0, 2) == 0, 1'b1);
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus the long hold, counted here
  // ---------------------------------------------------------------------------

  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        result_stall <= 1'b0;
      end else if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else if (!steady && $urandom_range(0, 99) < 15) begin
        result_stall <= 1'b1;
        stall_left = gap_len() - 1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Compare each taken word against the oldest pending verdict
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: text_matches=%0b at cycle %0d",
                   text_matches, cycle_count);
      end else begin
        expected_match = verdicts_due.pop_front();
        if (text_matches !== expected_match) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("text_matches mismatch: expected %0b, got %0b at cycle %0d",
                     expected_match, text_matches, cycle_count);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("wildcard_pattern_matcher_unit_tb: FAIL");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    text_byte    = '0;
    byte_present = 1'b0;
    end_of_text  = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    steady       = 1'b0;
    words_sent   = 0;
    hold_left    = 0;
    stall_left   = 0;
    mismatches   = 0;
    for (int i = 0; i < 4; i++) pattern_word[i] = '0;
    pattern_len_reg = '0;
    live_positions  = wpm_pkg::START_SET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_pattern();
    test_wildcards();
    test_extreme_bytes();
    test_long_length();
    test_unknown_index();
    test_midtext_reconfig();
    test_backpressure();
    test_random_texts();
    wait_drain();

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("wildcard_pattern_matcher_unit_tb: PASS");
    end else begin
      $display("wildcard_pattern_matcher_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
